@@ rtl/core/tmsrob_pkg.sv @@
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none
package tmsrob_pkg;

  localparam int STATIONS  = 8;
  localparam int ROB_DEPTH = 16;
  localparam int NUM_REGS  = 32;
  localparam int MEM_BYTES = 4096;

  localparam int KIND_W  = 2;
  localparam int OP_W    = 4;
  localparam int REG_W   = 5;
  localparam int IMM_W   = 12;
  localparam int PADDR_W = 12;
  localparam int WORD_W  = 32;

  localparam logic [KIND_W-1:0] KIND_ISSUE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRELOAD = 2'd2;

  localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd2;
  localparam logic [OP_W-1:0] OP_AND  = 4'd3;
  localparam logic [OP_W-1:0] OP_OR   = 4'd4;
  localparam logic [OP_W-1:0] OP_XOR  = 4'd5;
  localparam logic [OP_W-1:0] OP_ADDI = 4'd6;
  localparam logic [OP_W-1:0] OP_SLTI = 4'd7;
  localparam logic [OP_W-1:0] OP_LW   = 4'd8;
  localparam logic [OP_W-1:0] OP_SW   = 4'd9;

  typedef struct packed {
    logic load;
    logic grab;
    logic nop_take;
    logic issue_a;
    logic issue_b;
    logic preload;
    logic bcast;
    logic start;
    logic exec;
    logic mem_go;
    logic mem_rd;
    logic complete;
    logic retire;
    logic out_load;
    logic clr;
  } tmsrob_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              op_real;
    logic              can_issue;
    logic              pick_any;
    logic              is_mem;
    logic              is_load;
    logic              ret_ok;
    logic              clr_done;
  } tmsrob_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/tomasulo_rob_core.sv @@
// top level of the out-of-order core with reservation stations and reorder buffer
//
// usage
//   input channel (in_valid/in_ready) carries one word per item: issue an
//   instruction, advance one clock step, or preload a data memory word.
//   result channel (out_valid/out_ready) returns one word per item with
//   the accept flag, step activity, bus broadcast, retire count, pc and
//   reorder buffer occupancy.
// sequencing
//   nop, preload or stall: decode, result. issue: decode, read a, read b, result.
//   clock step: broadcast, start; if a station completes, execute, memory access
//   (store or load), memory read (load), complete; then retire ready head entries,
//   result. one item is worked on at a time; the retire walk sets the long case.
// reset
//   rst_n low clears all control state; afterwards the data memory is
//   zeroed one word row per cycle, with in_ready low.
// stalls
//   a finished result sits in the output register; the next item is taken
//   while it waits, and its own result holds until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module tomasulo_rob_core #(
  parameter int STATIONS  = tmsrob_pkg::STATIONS,
  parameter int ROB_DEPTH = tmsrob_pkg::ROB_DEPTH,
  parameter int NUM_REGS  = tmsrob_pkg::NUM_REGS,
  parameter int MEM_BYTES = tmsrob_pkg::MEM_BYTES,
  localparam int TW = $clog2(ROB_DEPTH),
  localparam int CW = $clog2(ROB_DEPTH + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tmsrob_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [tmsrob_pkg::OP_W-1:0]         in_opcode,
  input  wire logic [tmsrob_pkg::REG_W-1:0]        in_dest_reg,
  input  wire logic [tmsrob_pkg::REG_W-1:0]        in_src_reg_a,
  input  wire logic [tmsrob_pkg::REG_W-1:0]        in_src_reg_b,
  input  wire logic signed [tmsrob_pkg::IMM_W-1:0] in_immediate,
  input  wire logic [tmsrob_pkg::PADDR_W-1:0]      in_preload_addr,
  input  wire logic [tmsrob_pkg::WORD_W-1:0]       in_preload_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_accepted,
  output logic                                     out_started_any,
  output logic                                     out_bus_valid,
  output logic [TW-1:0]                            out_bus_tag,
  output logic [tmsrob_pkg::WORD_W-1:0]            out_bus_value,
  output logic [CW-1:0]                            out_retired_count,
  output logic [tmsrob_pkg::WORD_W-1:0]            out_program_counter,
  output logic [CW-1:0]                            out_occupancy
);

  // command and status between sequencer and datapath
  tmsrob_pkg::tmsrob_cmd_t  cmd;
  tmsrob_pkg::tmsrob_stat_t st;

  tmsrob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tmsrob_dp #(
    .STATIONS  (STATIONS),
    .ROB_DEPTH (ROB_DEPTH),
    .NUM_REGS  (NUM_REGS),
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_kind             (in_kind),
    .in_opcode           (in_opcode),
    .in_dest_reg         (in_dest_reg),
    .in_src_reg_a        (in_src_reg_a),
    .in_src_reg_b        (in_src_reg_b),
    .in_immediate        (in_immediate),
    .in_preload_addr     (in_preload_addr),
    .in_preload_data     (in_preload_data),
    .out_accepted        (out_accepted),
    .out_started_any     (out_started_any),
    .out_bus_valid       (out_bus_valid),
    .out_bus_tag         (out_bus_tag),
    .out_bus_value       (out_bus_value),
    .out_retired_count   (out_retired_count),
    .out_program_counter (out_program_counter),
    .out_occupancy       (out_occupancy)
  );

endmodule
`default_nettype wire

@@ rtl/core/tmsrob_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tmsrob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/tmsrob_ctrl.sv @@
// sequencing state machine for issue, clock step, preload and clearing
`timescale 1ns / 1ps
`default_nettype none
module tmsrob_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire tmsrob_pkg::tmsrob_stat_t st,
  output tmsrob_pkg::tmsrob_cmd_t     cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_ISA  = 4'd3;
  localparam logic [3:0] S_ISB  = 4'd4;
  localparam logic [3:0] S_BC   = 4'd5;
  localparam logic [3:0] S_ST   = 4'd6;
  localparam logic [3:0] S_EX   = 4'd7;
  localparam logic [3:0] S_MA   = 4'd8;
  localparam logic [3:0] S_MR   = 4'd9;
  localparam logic [3:0] S_CM   = 4'd10;
  localparam logic [3:0] S_RT   = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (st.kind)
          tmsrob_pkg::KIND_ISSUE: begin
            if (!st.op_real) begin
              cmd.nop_take = 1'b1;
              state_nxt    = S_FIN;
            end else if (st.can_issue) begin
              cmd.grab  = 1'b1;
              state_nxt = S_ISA;
            end else begin
              state_nxt = S_FIN;
            end
          end
          tmsrob_pkg::KIND_STEP: state_nxt = S_BC;
          tmsrob_pkg::KIND_PRELOAD: begin
            cmd.preload = 1'b1;
            state_nxt   = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_ISA: begin
        cmd.issue_a = 1'b1;
        state_nxt   = S_ISB;
      end
      S_ISB: begin
        cmd.issue_b = 1'b1;
        state_nxt   = S_FIN;
      end
      S_BC: begin
        cmd.bcast = 1'b1;
        state_nxt = S_ST;
      end
      S_ST: begin
        cmd.start = 1'b1;
        state_nxt = st.pick_any ? S_EX : S_RT;
      end
      S_EX: begin
        cmd.exec  = 1'b1;
        state_nxt = st.is_mem ? S_MA : S_CM;
      end
      S_MA: begin
        cmd.mem_go = 1'b1;
        state_nxt  = st.is_load ? S_MR : S_CM;
      end
      S_MR: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_CM;
      end
      S_CM: begin
        cmd.complete = 1'b1;
        state_nxt    = S_RT;
      end
      S_RT: begin
        if (st.ret_ok) cmd.retire = 1'b1;
        else           state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/core/tmsrob_dp.sv @@
// datapath: registers, rename map, stations, reorder buffer, alu and data memory
`timescale 1ns / 1ps
`default_nettype none
module tmsrob_dp #(
  parameter int STATIONS  = tmsrob_pkg::STATIONS,
  parameter int ROB_DEPTH = tmsrob_pkg::ROB_DEPTH,
  parameter int NUM_REGS  = tmsrob_pkg::NUM_REGS,
  parameter int MEM_BYTES = tmsrob_pkg::MEM_BYTES,
  localparam int TW = $clog2(ROB_DEPTH),
  localparam int CW = $clog2(ROB_DEPTH + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tmsrob_pkg::tmsrob_cmd_t            cmd,
  output tmsrob_pkg::tmsrob_stat_t                st,
  input  wire logic [tmsrob_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [tmsrob_pkg::OP_W-1:0]        in_opcode,
  input  wire logic [tmsrob_pkg::REG_W-1:0]       in_dest_reg,
  input  wire logic [tmsrob_pkg::REG_W-1:0]       in_src_reg_a,
  input  wire logic [tmsrob_pkg::REG_W-1:0]       in_src_reg_b,
  input  wire logic signed [tmsrob_pkg::IMM_W-1:0] in_immediate,
  input  wire logic [tmsrob_pkg::PADDR_W-1:0]     in_preload_addr,
  input  wire logic [tmsrob_pkg::WORD_W-1:0]      in_preload_data,
  output logic                                    out_accepted,
  output logic                                    out_started_any,
  output logic                                    out_bus_valid,
  output logic [TW-1:0]                           out_bus_tag,
  output logic [tmsrob_pkg::WORD_W-1:0]           out_bus_value,
  output logic [CW-1:0]                           out_retired_count,
  output logic [tmsrob_pkg::WORD_W-1:0]           out_program_counter,
  output logic [CW-1:0]                           out_occupancy
);

  localparam int OPW   = tmsrob_pkg::OP_W;
  localparam int RW    = tmsrob_pkg::REG_W;
  localparam int IW    = tmsrob_pkg::IMM_W;
  localparam int WW    = tmsrob_pkg::WORD_W;
  localparam int SIW   = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int RIW   = $clog2(NUM_REGS);
  localparam int XW    = (RIW > RW) ? RIW : RW;
  localparam int LANE_DEPTH = (MEM_BYTES + 3) / 4;
  localparam int LW    = $clog2(LANE_DEPTH);
  localparam logic [WW-1:0] FIT_MAX = WW'(MEM_BYTES - 4);

  // latched item
  logic [tmsrob_pkg::KIND_W-1:0]  kind_r;
  logic [OPW-1:0]                 op_r;
  logic [RW-1:0]                  rd_r, ra_r, rb_r;
  logic [IW-1:0]                  imm_r;
  logic [tmsrob_pkg::PADDR_W-1:0] paddr_r;
  logic [WW-1:0]                  pdata_r;

  // architectural registers and rename map
  logic [WW-1:0] rf_r   [NUM_REGS];
  logic          pend_r [NUM_REGS];
  logic [TW-1:0] map_r  [NUM_REGS];

  // stations
  logic           st_busy_r [STATIONS];
  logic           st_exec_r [STATIONS];
  logic           st_wav_r  [STATIONS];
  logic           st_wbv_r  [STATIONS];
  logic [OPW-1:0] st_op_r   [STATIONS];
  logic [WW-1:0]  st_va_r   [STATIONS];
  logic [WW-1:0]  st_vb_r   [STATIONS];
  logic [IW-1:0]  st_imm_r  [STATIONS];
  logic [TW-1:0]  st_wa_r   [STATIONS];
  logic [TW-1:0]  st_wb_r   [STATIONS];
  logic [TW-1:0]  st_dt_r   [STATIONS];

  // reorder buffer
  logic          rob_busy_r  [ROB_DEPTH];
  logic          rob_ready_r [ROB_DEPTH];
  logic [TW-1:0] head_r, tail_r;
  logic [CW-1:0] used_r;

  logic          bus_v_r;
  logic [TW-1:0] bus_t_r;
  logic [WW-1:0] bus_val_r;
  logic [WW-1:0] pc_r;

  logic [SIW-1:0] slot_r, pick_r;
  logic [WW-1:0]  res_r, addr_r;
  logic [1:0]     off_r;
  logic           fit_r;
  logic [LW-1:0]  clr_cnt_r;

  // per-item results
  logic          acc_r, started_r, ibus_r;
  logic [CW-1:0] ret_r;

  // ---- source read through one shared port
  logic [RW-1:0]  src_sel;
  logic [XW-1:0]  src_x;
  logic [RIW-1:0] src_idx;
  logic           src_rng, src_pend;
  logic [WW-1:0]  src_val;
  logic [TW-1:0]  src_tag;

  always_comb begin
    src_sel  = cmd.issue_b ? rb_r : ra_r;
    src_x    = XW'(src_sel);
    src_idx  = src_x[RIW-1:0];
    src_rng  = (src_sel != '0) && (32'(src_sel) < NUM_REGS);
    src_pend = src_rng && pend_r[src_idx];
    src_val  = (src_rng && !src_pend) ? rf_r[src_idx] : '0;
    src_tag  = src_pend ? map_r[src_idx] : '0;
  end

  logic [XW-1:0]  rd_x;
  logic [RIW-1:0] rd_idx;
  logic           rd_ok;
  assign rd_x   = XW'(rd_r);
  assign rd_idx = rd_x[RIW-1:0];
  assign rd_ok  = (rd_r != '0) && (32'(rd_r) < NUM_REGS) && (op_r != tmsrob_pkg::OP_SW);

  logic uses_b;
  assign uses_b = (op_r <= tmsrob_pkg::OP_XOR) || (op_r == tmsrob_pkg::OP_SW);

  // ---- free station and completion pick
  logic [SIW-1:0] free_idx, pick_idx;
  logic           free_any, pick_any, start_any;
  logic           st_rdy [STATIONS];

  always_comb begin
    free_idx  = '0;
    free_any  = 1'b0;
    pick_idx  = '0;
    pick_any  = 1'b0;
    start_any = 1'b0;
    for (int i = STATIONS - 1; i >= 0; i--) begin
      st_rdy[i] = st_busy_r[i] && !st_exec_r[i] && !st_wav_r[i] && !st_wbv_r[i];
      if (!st_busy_r[i]) begin
        free_idx = SIW'(i);
        free_any = 1'b1;
      end
      if (st_busy_r[i] && (st_exec_r[i] || st_rdy[i])) begin
        pick_idx = SIW'(i);
        pick_any = 1'b1;
      end
      if (st_rdy[i]) start_any = 1'b1;
    end
  end

  // ---- alu on the picked station
  logic [OPW-1:0] ex_op;
  logic [WW-1:0]  ex_a, ex_b, ex_imm, ex_res;

  always_comb begin
    ex_op  = st_op_r[pick_r];
    ex_a   = st_va_r[pick_r];
    ex_b   = st_vb_r[pick_r];
    ex_imm = {{(WW-IW){st_imm_r[pick_r][IW-1]}}, st_imm_r[pick_r]};
    case (ex_op)
      tmsrob_pkg::OP_ADD:  ex_res = ex_a + ex_b;
      tmsrob_pkg::OP_SUB:  ex_res = ex_a - ex_b;
      tmsrob_pkg::OP_AND:  ex_res = ex_a & ex_b;
      tmsrob_pkg::OP_OR:   ex_res = ex_a | ex_b;
      tmsrob_pkg::OP_XOR:  ex_res = ex_a ^ ex_b;
      tmsrob_pkg::OP_ADDI: ex_res = ex_a + ex_imm;
      tmsrob_pkg::OP_SLTI: ex_res = WW'($signed(ex_a) < $signed(ex_imm));
      default:             ex_res = '0;
    endcase
  end

  // ---- data memory: four byte lanes, unaligned little-endian words
  logic [WW-1:0] m_addr, m_wdata;
  logic          m_fit, m_we;
  logic [1:0]    m_off;
  logic [LW-1:0] m_base;
  logic [LW-1:0] lane_addr  [4];
  logic [7:0]    lane_wdata [4];
  logic          lane_we    [4];
  logic [7:0]    lane_rdata [4];
  logic [WW-1:0] ld_word;

  always_comb begin
    m_addr  = cmd.preload ? WW'(paddr_r) : addr_r;
    m_wdata = cmd.preload ? pdata_r : ex_b;
    m_fit   = (m_addr <= FIT_MAX);
    m_off   = m_addr[1:0];
    m_base  = m_addr[LW+1:2];
    m_we    = m_fit && (cmd.preload || (cmd.mem_go && ex_op == tmsrob_pkg::OP_SW));
    for (int k = 0; k < 4; k++) begin
      if (cmd.clr) begin
        lane_addr[k]  = clr_cnt_r;
        lane_wdata[k] = '0;
        lane_we[k]    = 1'b1;
      end else begin
        lane_addr[k]  = m_base + LW'(2'(k) < m_off);
        lane_wdata[k] = m_wdata[8*(2'(2'(k) - m_off)) +: 8];
        lane_we[k]    = m_we;
      end
    end
    for (int j = 0; j < 4; j++) begin
      ld_word[8*j +: 8] = lane_rdata[2'(off_r + 2'(j))];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    tmsrob_ram #(
      .WIDTH (8),
      .DEPTH (LANE_DEPTH)
    ) u_lane (
      .clk   (clk),
      .we    (lane_we[k]),
      .addr  (lane_addr[k]),
      .wdata (lane_wdata[k]),
      .rdata (lane_rdata[k])
    );
  end

  logic ret_ok;
  assign ret_ok = (used_r != '0) && rob_busy_r[head_r] && rob_ready_r[head_r];

  function automatic logic [TW-1:0] ptr_inc(input logic [TW-1:0] p);
    ptr_inc = (p == TW'(ROB_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      op_r    <= in_opcode;
      rd_r    <= in_dest_reg;
      ra_r    <= in_src_reg_a;
      rb_r    <= in_src_reg_b;
      imm_r   <= in_immediate;
      paddr_r <= in_preload_addr;
      pdata_r <= in_preload_data;
    end
    if (cmd.grab)  slot_r <= free_idx;
    if (cmd.start) pick_r <= pick_idx;
    if (cmd.exec) begin
      res_r  <= ex_res;
      addr_r <= ex_a + ex_imm;
    end
    if (cmd.mem_go) begin
      off_r <= m_off;
      fit_r <= m_fit;
    end
    if (cmd.mem_rd) res_r <= fit_r ? ld_word : '0;
    if (cmd.complete) begin
      bus_t_r   <= st_dt_r[pick_r];
      bus_val_r <= res_r;
    end
    if (cmd.issue_a) begin
      st_op_r[slot_r]  <= op_r;
      st_imm_r[slot_r] <= imm_r;
      st_dt_r[slot_r]  <= tail_r;
      st_wa_r[slot_r]  <= src_tag;
      st_va_r[slot_r]  <= src_val;
    end
    if (cmd.issue_b) begin
      st_wb_r[slot_r] <= uses_b ? src_tag : '0;
      st_vb_r[slot_r] <= uses_b ? src_val : '0;
    end
    if (cmd.bcast && bus_v_r) begin
      for (int i = 0; i < STATIONS; i++) begin
        if (st_busy_r[i] && st_wav_r[i] && st_wa_r[i] == bus_t_r) st_va_r[i] <= bus_val_r;
        if (st_busy_r[i] && st_wbv_r[i] && st_wb_r[i] == bus_t_r) st_vb_r[i] <= bus_val_r;
      end
    end
    if (cmd.out_load) begin
      out_accepted        <= acc_r;
      out_started_any     <= started_r;
      out_bus_valid       <= ibus_r;
      out_bus_tag         <= ibus_r ? bus_t_r : '0;
      out_bus_value       <= ibus_r ? bus_val_r : '0;
      out_retired_count   <= ret_r;
      out_program_counter <= pc_r;
      out_occupancy       <= used_r;
    end
  end

  // ---- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i]   <= '0;
        pend_r[i] <= 1'b0;
        map_r[i]  <= '0;
      end
      for (int i = 0; i < STATIONS; i++) begin
        st_busy_r[i] <= 1'b0;
        st_exec_r[i] <= 1'b0;
        st_wav_r[i]  <= 1'b0;
        st_wbv_r[i]  <= 1'b0;
      end
      for (int i = 0; i < ROB_DEPTH; i++) begin
        rob_busy_r[i]  <= 1'b0;
        rob_ready_r[i] <= 1'b0;
      end
      head_r    <= '0;
      tail_r    <= '0;
      used_r    <= '0;
      bus_v_r   <= 1'b0;
      pc_r      <= '0;
      clr_cnt_r <= '0;
      acc_r     <= 1'b0;
      started_r <= 1'b0;
      ibus_r    <= 1'b0;
      ret_r     <= '0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.load) begin
        acc_r     <= 1'b0;
        started_r <= 1'b0;
        ibus_r    <= 1'b0;
        ret_r     <= '0;
      end
      if (cmd.nop_take) begin
        acc_r <= 1'b1;
        pc_r  <= pc_r + 32'd4;
      end
      if (cmd.issue_a) begin
        st_busy_r[slot_r] <= 1'b1;
        st_exec_r[slot_r] <= 1'b0;
        st_wav_r[slot_r]  <= src_pend;
      end
      if (cmd.issue_b) begin
        st_wbv_r[slot_r]    <= uses_b && src_pend;
        rob_busy_r[tail_r]  <= 1'b1;
        rob_ready_r[tail_r] <= 1'b0;
        if (rd_ok) begin
          pend_r[rd_idx] <= 1'b1;
          map_r[rd_idx]  <= tail_r;
        end
        tail_r <= ptr_inc(tail_r);
        used_r <= used_r + 1'b1;
        pc_r   <= pc_r + 32'd4;
        acc_r  <= 1'b1;
      end
      if (cmd.bcast && bus_v_r) begin
        rob_ready_r[bus_t_r] <= 1'b1;
        for (int i = 1; i < NUM_REGS; i++) begin
          if (pend_r[i] && map_r[i] == bus_t_r) begin
            rf_r[i]   <= bus_val_r;
            pend_r[i] <= 1'b0;
          end
        end
        for (int i = 0; i < STATIONS; i++) begin
          if (st_busy_r[i] && st_wav_r[i] && st_wa_r[i] == bus_t_r) st_wav_r[i] <= 1'b0;
          if (st_busy_r[i] && st_wbv_r[i] && st_wb_r[i] == bus_t_r) st_wbv_r[i] <= 1'b0;
        end
        bus_v_r <= 1'b0;
      end
      if (cmd.start) begin
        for (int i = 0; i < STATIONS; i++) begin
          if (st_rdy[i]) st_exec_r[i] <= 1'b1;
        end
        started_r <= start_any;
      end
      if (cmd.complete) begin
        bus_v_r           <= 1'b1;
        ibus_r            <= 1'b1;
        st_busy_r[pick_r] <= 1'b0;
        st_exec_r[pick_r] <= 1'b0;
      end
      if (cmd.retire) begin
        rob_busy_r[head_r] <= 1'b0;
        head_r             <= ptr_inc(head_r);
        used_r             <= used_r - 1'b1;
        ret_r              <= ret_r + 1'b1;
      end
    end
  end

  always_comb begin
    st.kind      = kind_r;
    st.op_real   = (op_r >= tmsrob_pkg::OP_ADD) && (op_r <= tmsrob_pkg::OP_SW);
    st.can_issue = free_any && (used_r != CW'(ROB_DEPTH));
    st.pick_any  = pick_any;
    st.is_mem    = (ex_op == tmsrob_pkg::OP_LW) || (ex_op == tmsrob_pkg::OP_SW);
    st.is_load   = (ex_op == tmsrob_pkg::OP_LW);
    st.ret_ok    = ret_ok;
    st.clr_done  = (clr_cnt_r == LW'(LANE_DEPTH - 1));
  end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for the out-of-order core with reorder buffer
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import tmsrob_pkg::*;

  // one input word as driven on the in_ ports
  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [OP_W-1:0]         opcode;
    logic [REG_W-1:0]        dest;
    logic [REG_W-1:0]        src_a;
    logic [REG_W-1:0]        src_b;
    logic signed [IMM_W-1:0] imm;
    logic [PADDR_W-1:0]      paddr;
    logic [WORD_W-1:0]       pdata;
  } core_item_t;

  // one result word as seen on the out_ ports
  typedef struct {
    logic        accepted;
    logic        started_any;
    logic        bus_valid;
    logic [3:0]  bus_tag;
    logic [31:0] bus_value;
    logic [4:0]  retired_count;
    logic [31:0] pc;
    logic [4:0]  occupancy;
  } core_res_t;

  localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;
  localparam int N_RANDOM = 1200;

  // shadow core: tracks the architectural and scheduling state and
  // predicts the result word for every accepted input word
  class core_scoreboard;
    logic [31:0] regs[NUM_REGS];
    bit          pend[NUM_REGS];
    logic [3:0]  map_tag[NUM_REGS];
    bit          st_busy[STATIONS];
    bit          st_exec[STATIONS];
    logic [3:0]  st_op[STATIONS];
    logic [31:0] st_a[STATIONS];
    logic [31:0] st_b[STATIONS];
    logic [11:0] st_imm[STATIONS];
    bit          st_wa_v[STATIONS];
    logic [3:0]  st_wa[STATIONS];
    bit          st_wb_v[STATIONS];
    logic [3:0]  st_wb[STATIONS];
    logic [3:0]  st_tag[STATIONS];
    bit          rb_busy[ROB_DEPTH];
    bit          rb_ready[ROB_DEPTH];
    int          head, tail, used;
    bit          lat_v;
    logic [3:0]  lat_tag;
    logic [31:0] lat_val;
    logic [31:0] pc;
    logic [7:0]  mem[MEM_BYTES];
    core_res_t   pending_q[$];
    int          errors;

    function new();
      foreach (regs[i]) begin regs[i] = 0; pend[i] = 0; map_tag[i] = 0; end
      foreach (st_busy[i]) begin
        st_busy[i] = 0; st_exec[i] = 0; st_wa_v[i] = 0; st_wb_v[i] = 0;
      end
      foreach (rb_busy[i]) begin rb_busy[i] = 0; rb_ready[i] = 0; end
      foreach (mem[i]) mem[i] = 0;
      head = 0; tail = 0; used = 0; lat_v = 0; pc = 0; errors = 0;
    endfunction

    function logic [31:0] mem_rd(logic [31:0] addr);
      if (addr > MEM_BYTES - 4) return 0;
      return {mem[addr+3], mem[addr+2], mem[addr+1], mem[addr]};
    endfunction

    function void mem_wr(logic [31:0] addr, logic [31:0] v);
      if (addr > MEM_BYTES - 4) return;
      {mem[addr+3], mem[addr+2], mem[addr+1], mem[addr]} = v;
    endfunction

    // pending source gives its tag, ready source its value, reg zero reads 0
    function void read_src(logic [4:0] r, output bit wv, output logic [3:0] wt,
                           output logic [31:0] v);
      wv = 0; wt = 0; v = 0;
      if (r == 0) return;
      if (pend[r]) begin wv = 1; wt = map_tag[r]; end
      else v = regs[r];
    endfunction

    function logic [31:0] exec_op(int s);
      logic [31:0] immx;
      immx = {{20{st_imm[s][11]}}, st_imm[s]};
      case (st_op[s])
        OP_ADD:  return st_a[s] + st_b[s];
        OP_SUB:  return st_a[s] - st_b[s];
        OP_AND:  return st_a[s] & st_b[s];
        OP_OR:   return st_a[s] | st_b[s];
        OP_XOR:  return st_a[s] ^ st_b[s];
        OP_ADDI: return st_a[s] + immx;
        OP_SLTI: return ($signed(st_a[s]) < $signed(immx)) ? 32'd1 : 32'd0;
        OP_LW:   return mem_rd(st_a[s] + immx);
        OP_SW: begin mem_wr(st_a[s] + immx, st_b[s]); return 0; end
        default: return 0;
      endcase
    endfunction

    function bit issue(core_item_t it);
      int s;
      logic [3:0] t;
      s = -1;
      if (it.opcode == OP_NOP || it.opcode > OP_SW) begin pc += 4; return 1; end
      for (int i = STATIONS - 1; i >= 0; i--) if (!st_busy[i]) s = i;
      if (s < 0 || used >= ROB_DEPTH) return 0;
      t = tail[3:0];
      st_busy[s] = 1; st_exec[s] = 0; st_op[s] = it.opcode; st_imm[s] = it.imm;
      st_tag[s] = t;
      read_src(it.src_a, st_wa_v[s], st_wa[s], st_a[s]);
      if (it.opcode <= OP_XOR || it.opcode == OP_SW)
        read_src(it.src_b, st_wb_v[s], st_wb[s], st_b[s]);
      else begin st_wb_v[s] = 0; st_wb[s] = 0; st_b[s] = 0; end
      rb_busy[t] = 1; rb_ready[t] = 0;
      if (it.opcode != OP_SW && it.dest != 0) begin pend[it.dest] = 1; map_tag[it.dest] = t; end
      tail = (tail + 1) % ROB_DEPTH;
      used++;
      pc += 4;
      return 1;
    endfunction

    function void clock_step(ref core_res_t r);
      if (lat_v) begin
        rb_ready[lat_tag] = 1;
        for (int i = 1; i < NUM_REGS; i++)
          if (pend[i] && map_tag[i] == lat_tag) begin regs[i] = lat_val; pend[i] = 0; end
        for (int i = 0; i < STATIONS; i++) if (st_busy[i]) begin
          if (st_wa_v[i] && st_wa[i] == lat_tag) begin st_a[i] = lat_val; st_wa_v[i] = 0; end
          if (st_wb_v[i] && st_wb[i] == lat_tag) begin st_b[i] = lat_val; st_wb_v[i] = 0; end
        end
        lat_v = 0;
      end
      for (int i = 0; i < STATIONS; i++)
        if (st_busy[i] && !st_exec[i] && !st_wa_v[i] && !st_wb_v[i]) begin
          st_exec[i] = 1; r.started_any = 1;
        end
      for (int i = 0; i < STATIONS; i++)
        if (st_busy[i] && st_exec[i]) begin
          lat_val = exec_op(i); lat_tag = st_tag[i]; lat_v = 1;
          st_busy[i] = 0; st_exec[i] = 0;
          r.bus_valid = 1; r.bus_tag = lat_tag; r.bus_value = lat_val;
          break;
        end
      while (used > 0 && rb_busy[head] && rb_ready[head]) begin
        rb_busy[head] = 0; head = (head + 1) % ROB_DEPTH; used--; r.retired_count++;
      end
    endfunction

    function void note_input(core_item_t it);
      core_res_t r;
      r = '{default: 0};
      case (it.kind)
        KIND_ISSUE:   r.accepted = issue(it);
        KIND_STEP:    clock_step(r);
        KIND_PRELOAD: mem_wr({20'd0, it.paddr}, it.pdata);
        default: ;
      endcase
      r.pc = pc;
      r.occupancy = used[4:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(core_res_t got);
      core_res_t e;
      if (pending_q.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.accepted !== e.accepted) begin
        $error("accepted: expected %0d actual %0d", e.accepted, got.accepted); errors++;
      end
      if (got.started_any !== e.started_any) begin
        $error("started_any: expected %0d actual %0d", e.started_any, got.started_any);
        errors++;
      end
      if (got.bus_valid !== e.bus_valid) begin
        $error("bus_valid: expected %0d actual %0d", e.bus_valid, got.bus_valid); errors++;
      end
      if (got.bus_tag !== e.bus_tag) begin
        $error("bus_tag: expected %0d actual %0d", e.bus_tag, got.bus_tag); errors++;
      end
      if (got.bus_value !== e.bus_value) begin
        $error("bus_value: expected %h actual %h", e.bus_value, got.bus_value); errors++;
      end
      if (got.retired_count !== e.retired_count) begin
        $error("retired_count: expected %0d actual %0d", e.retired_count, got.retired_count);
        errors++;
      end
      if (got.pc !== e.pc) begin
        $error("program_counter: expected %h actual %h", e.pc, got.pc); errors++;
      end
      if (got.occupancy !== e.occupancy) begin
        $error("occupancy: expected %0d actual %0d", e.occupancy, got.occupancy); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic out_ready = 0;
  logic in_ready, out_valid;
  logic [KIND_W-1:0] in_kind = 0;
  logic [OP_W-1:0] in_opcode = 0;
  logic [REG_W-1:0] in_dest_reg = 0, in_src_reg_a = 0, in_src_reg_b = 0;
  logic signed [IMM_W-1:0] in_immediate = 0;
  logic [PADDR_W-1:0] in_preload_addr = 0;
  logic [WORD_W-1:0] in_preload_data = 0;
  logic out_accepted, out_started_any, out_bus_valid;
  logic [3:0] out_bus_tag;
  logic [31:0] out_bus_value, out_program_counter;
  logic [4:0] out_retired_count, out_occupancy;

  core_scoreboard sb = new();
  int results_seen = 0;

  always #2 clk = ~clk;

  tomasulo_rob_core #(.STATIONS(STATIONS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_opcode(in_opcode), .in_dest_reg(in_dest_reg),
    .in_src_reg_a(in_src_reg_a), .in_src_reg_b(in_src_reg_b),
    .in_immediate(in_immediate), .in_preload_addr(in_preload_addr),
    .in_preload_data(in_preload_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accepted(out_accepted), .out_started_any(out_started_any),
    .out_bus_valid(out_bus_valid), .out_bus_tag(out_bus_tag),
    .out_bus_value(out_bus_value), .out_retired_count(out_retired_count),
    .out_program_counter(out_program_counter), .out_occupancy(out_occupancy)
  );

  // drive one word: random gap, then hold valid until the handshake
  task automatic send_word(core_item_t it);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= it.kind; in_opcode <= it.opcode; in_dest_reg <= it.dest;
    in_src_reg_a <= it.src_a; in_src_reg_b <= it.src_b; in_immediate <= it.imm;
    in_preload_addr <= it.paddr; in_preload_data <= it.pdata;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  function automatic core_item_t mk_word(int k, int op, int rd, int ra, int rb, int imm,
                                         int pa, int pd);
    core_item_t it;
    it.kind = KIND_W'(k); it.opcode = OP_W'(op); it.dest = REG_W'(rd);
    it.src_a = REG_W'(ra); it.src_b = REG_W'(rb);
    it.imm = IMM_W'(imm); it.paddr = PADDR_W'(pa); it.pdata = WORD_W'(pd);
    return it;
  endfunction

  // random word: mostly issues on a small register set and clock steps
  function automatic core_item_t rand_word();
    core_item_t it;
    int sel;
    it = mk_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    sel = $urandom_range(0, 99);
    if (sel < 48) begin
      it.kind = KIND_ISSUE;
      it.opcode = OP_W'($urandom_range(1, 9));
      if ($urandom_range(0, 9) == 0) it.opcode = OP_W'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0) begin
        it.dest = REG_W'($urandom_range(0, 7));
        it.src_a = REG_W'($urandom_range(0, 7));
        it.src_b = REG_W'($urandom_range(0, 7));
      end
      if ((it.opcode == OP_LW || it.opcode == OP_SW) && $urandom_range(0, 2) != 0)
        it.imm = IMM_W'($urandom_range(0, 255) << 2);
    end else if (sel < 92) it.kind = KIND_STEP;
    else if (sel < 98) begin
      it.kind = KIND_PRELOAD;
      if ($urandom_range(0, 2) != 0) it.paddr = PADDR_W'($urandom_range(0, 255) << 2);
    end else it.kind = KIND_UNDEF;
    return it;
  endfunction

  // receiver: random stalls, and one long hold-off that backs up the input
  initial begin : receiver
    int n;
    core_res_t r;
    @(posedge rst_n);
    forever begin
      n = (results_seen == 150) ? 300 : $urandom_range(0, 4);
      if (results_seen > 400 && results_seen < 500) n = 0;
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      r.accepted = out_accepted; r.started_any = out_started_any;
      r.bus_valid = out_bus_valid; r.bus_tag = out_bus_tag; r.bus_value = out_bus_value;
      r.retired_count = out_retired_count; r.pc = out_program_counter;
      r.occupancy = out_occupancy;
      sb.check_result(r);
      results_seen++;
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1;
    // directed: memory edges, every opcode, special cases
    send_word(mk_word(KIND_PRELOAD, 0, 0, 0, 0, 0, 4092, 32'hDEADBEEF));
    send_word(mk_word(KIND_PRELOAD, 0, 0, 0, 0, 0, 4093, 32'hFFFFFFFF));
    send_word(mk_word(KIND_PRELOAD, 0, 0, 0, 0, 0, 0, 32'h80000001));
    send_word(mk_word(KIND_ISSUE, OP_ADDI, 1, 0, 31, 12'h7FF, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_ADDI, 2, 0, 0, 12'h800, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_ADD, 3, 1, 2, 0, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_SUB, 4, 3, 1, 0, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_AND, 5, 2, 1, 0, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_OR, 6, 2, 1, 0, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_XOR, 0, 2, 1, 0, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_SLTI, 7, 2, 5, 12'h000, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_LW, 8, 0, 9, 12'hFFC, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_SW, 9, 0, 2, 16, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_NOP, 10, 1, 1, 0, 0, 0));
    send_word(mk_word(KIND_ISSUE, 15, 11, 1, 1, 0, 0, 0));
    send_word(mk_word(KIND_UNDEF, OP_ADD, 12, 1, 1, 0, 0, 0));
    repeat (12) send_word(mk_word(KIND_STEP, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_LW, 13, 0, 0, 16, 0, 0));
    send_word(mk_word(KIND_ISSUE, OP_LW, 14, 1, 0, 12'h7FF, 0, 0));
    repeat (N_RANDOM) send_word(rand_word());
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("PASS tomasulo_rob_core");
    else $display("FAIL tomasulo_rob_core");
    $finish;
  end

  // watchdog: far beyond the slowest correct run including memory clear
  initial begin : watchdog
    #4000000;
    $display("FAIL tomasulo_rob_core");
    $finish;
  end
endmodule
`default_nettype wire
